[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define HDRBG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Clocked check that also holds during reset.
`define HDRBG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

[rtl/core/hdrbg_pkg.sv]
// ----------------------------------------------------------------------------
// hdrbg_pkg
// Shared constants and types of the SHA-1 Hash_DRBG block.
// ----------------------------------------------------------------------------
`default_nettype none

package hdrbg_pkg;

  localparam int ENTROPY_BYTES = 128;
  localparam int NONCE_BYTES   = 8;
  localparam int MAX_REQ_BYTES = 200;
  localparam int SEED_CAP      = ENTROPY_BYTES + NONCE_BYTES;
  localparam int SEEDLEN       = 55;
  localparam int DIGLEN        = 20;
  localparam int SHA_ROUNDS    = 80;

  localparam logic [159:0] SHA1_IV =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  typedef enum logic [1:0] {
    STATUS_DATA   = 2'd0,
    STATUS_SEEDED = 2'd1,
    STATUS_RESEED = 2'd2
  } status_e;

  typedef struct packed {
    logic start;
    logic init;
  } sha_req_t;

  typedef struct packed {
    logic    byte_valid;
    logic    byte_final;
    logic    st_valid;
    status_e st_code;
  } pk_req_t;

endpackage

`default_nettype wire

[rtl/core/hdrbg_sha_core.sv]
// ----------------------------------------------------------------------------
// hdrbg_sha_core
// SHA-1 compression unit, one round per cycle with a 16-word schedule window.
// ----------------------------------------------------------------------------
`default_nettype none

module hdrbg_sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hdrbg_pkg::sha_req_t req_i,
  input  logic [511:0]       block_i,
  output logic [159:0]       digest_o,
  output logic               done_o
);
  import hdrbg_pkg::*;

  logic        busy_q;
  logic [6:0]  rnd_q;
  logic        done_q;
  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] h_q [5];
  logic [31:0] f_w, k_w, t_w, wn_w, x_w;

  always_comb begin
    if (rnd_q < 7'd20) begin
      f_w = (b_q & c_q) | (~b_q & d_q);
      k_w = 32'h5A827999;
    end else if (rnd_q < 7'd40) begin
      f_w = b_q ^ c_q ^ d_q;
      k_w = 32'h6ED9EBA1;
    end else if (rnd_q < 7'd60) begin
      f_w = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_w = 32'h8F1BBCDC;
    end else begin
      f_w = b_q ^ c_q ^ d_q;
      k_w = 32'hCA62C1D6;
    end
    t_w  = {a_q[26:0], a_q[31:27]} + f_w + e_q + k_w + w_q[0];
    x_w  = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wn_w = {x_w[30:0], x_w[31]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        if (rnd_q == 7'(SHA_ROUNDS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        rnd_q <= rnd_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= block_i[511 - 32*i -: 32];
      end
      if (req_i.init) begin
        for (int i = 0; i < 5; i++) begin
          h_q[i] <= SHA1_IV[159 - 32*i -: 32];
        end
        a_q <= SHA1_IV[159:128];
        b_q <= SHA1_IV[127:96];
        c_q <= SHA1_IV[95:64];
        d_q <= SHA1_IV[63:32];
        e_q <= SHA1_IV[31:0];
      end else begin
        a_q <= h_q[0];
        b_q <= h_q[1];
        c_q <= h_q[2];
        d_q <= h_q[3];
        e_q <= h_q[4];
      end
    end else if (busy_q) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= wn_w;
      a_q <= t_w;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      if (rnd_q == 7'(SHA_ROUNDS - 1)) begin
        h_q[0] <= h_q[0] + t_w;
        h_q[1] <= h_q[1] + a_q;
        h_q[2] <= h_q[2] + {b_q[1:0], b_q[31:2]};
        h_q[3] <= h_q[3] + c_q;
        h_q[4] <= h_q[4] + d_q;
      end
    end
  end

  assign digest_o = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
  assign done_o   = done_q;

endmodule

`default_nettype wire

[rtl/core/hdrbg_pack.sv]
// ----------------------------------------------------------------------------
// hdrbg_pack
// Packs generated bytes into 64-bit words and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hdrbg_pack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hdrbg_pkg::pk_req_t req_i,
  input  logic [7:0]         data_i,
  output logic               ready_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [71:0]        m_axis_tdata,  // random_word[63:0], valid_bytes[67:64], zero
  output logic               m_axis_tlast,
  output logic [1:0]         m_axis_tuser   // status[1:0]
);
  import hdrbg_pkg::*;

  logic [63:0] acc_q, word_q, acc_new;
  logic [2:0]  cnt_q;
  logic [3:0]  vb_q;
  logic        last_q, valid_q;
  status_e     st_q;
  logic        out_busy, flush, byte_go, st_go;

  assign out_busy = valid_q && !m_axis_tready;
  assign flush    = (cnt_q == 3'd7) || req_i.byte_final;
  assign ready_o  = req_i.byte_valid ? !(flush && out_busy) : !out_busy;
  assign byte_go  = req_i.byte_valid && ready_o;
  assign st_go    = req_i.st_valid && !req_i.byte_valid && ready_o;
  assign acc_new  = acc_q | ({data_i, 56'd0} >> {cnt_q, 3'b000});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      acc_q   <= '0;
    end else begin
      if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
      if (byte_go) begin
        if (flush) begin
          valid_q <= 1'b1;
          acc_q   <= '0;
          cnt_q   <= '0;
        end else begin
          acc_q <= acc_new;
          cnt_q <= cnt_q + 3'd1;
        end
      end else if (st_go) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_go && flush) begin
      word_q <= acc_new;
      vb_q   <= {1'b0, cnt_q} + 4'd1;
      last_q <= req_i.byte_final;
      st_q   <= STATUS_DATA;
    end else if (st_go) begin
      word_q <= '0;
      vb_q   <= '0;
      last_q <= 1'b1;
      st_q   <= req_i.st_code;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {4'd0, vb_q, word_q};
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = st_q;

endmodule

`default_nettype wire

[rtl/core/hash_drbg_sha1_top.sv]
// ----------------------------------------------------------------------------
// hash_drbg_sha1_top
// Hash_DRBG over SHA-1 with seeding, reseeding and generation.
// ----------------------------------------------------------------------------
// Items are handled one at a time; input ready is high only while the
// sequencer is idle. A seed byte that is not last is stored and leaves the
// sequencer idle. All work runs through one SHA-1 round unit (one round per
// cycle) and byte-wide memories for V, C and the seed bytes: every message
// byte is fetched through a read state and a write state, and every pass
// over V reads and writes it a byte at a time the same way. Seeding takes three
// Hash_df calls over the seed (one to four blocks each), a copy pass,
// and three two-block Hash_df calls for C. A generate first hashes 0x03 and V
// for the V update, then hashes V once per 20 output bytes with a counter
// increment pass between those hashes, and ends with the V update pass; the
// output side can stall the byte output. No clearing pass is needed after reset.
`default_nettype none

`include "assert_macros.svh"

module hash_drbg_sha1_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // seed_byte[7:0], request_bytes[15:8]
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // action[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // random_word[63:0], valid_bytes[67:64], zero
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] cfg_data_i
);
  import hdrbg_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_FILL_RD = 8'b0000_0010,
    ST_FILL_WR = 8'b0000_0100,
    ST_HASH    = 8'b0000_1000,
    ST_DIG     = 8'b0001_0000,
    ST_PASS_RD = 8'b0010_0000,
    ST_PASS_WR = 8'b0100_0000,
    ST_STATUS  = 8'b1000_0000
  } state_e;

  typedef enum logic [2:0] {
    JOB_INST, JOB_RESEED, JOB_DFC, JOB_GEN, JOB_HV
  } job_e;

  typedef enum logic [1:0] {
    PASS_COPY, PASS_INC, PASS_UPD
  } pass_e;

  typedef enum logic [1:0] {
    SRC_CONST, SRC_V, SRC_SEED
  } src_e;

  localparam logic [5:0] V_LAST = 6'(SEEDLEN - 1);

  state_e       state_q, state_d;
  job_e         job_q, job_d;
  pass_e        pass_q, pass_d;
  src_e         fsel_q, fsel_d;
  status_e      st_q, st_d;
  logic [7:0]   fconst_q, fconst_d;
  logic [1:0]   dfi_q, dfi_d;
  logic [8:0]   q_q, q_d, tot_q, tot_d;
  logic [7:0]   len_q, len_d;
  logic         first_q, first_d;
  logic [511:0] blk_q, blk_d;
  logic [5:0]   k_q, k_d;
  logic [2:0]   carry_q, carry_d;
  logic [3:0]   blocks_q, blocks_d;
  logic [7:0]   rem_q, rem_d;
  logic [31:0]  cnt_q, cnt_d;
  logic         seeded_q, seeded_d;
  logic [7:0]   fill_q, fill_d, nseed_q, nseed_d;
  logic [30:0]  limit_q;
  logic [159:0] hv_q, hv_d;

  logic [7:0] v_mem [SEEDLEN];
  logic [7:0] c_mem [SEEDLEN];
  logic [7:0] seed_mem [SEED_CAP];
  logic       v_we, c_we, seed_we;
  logic [5:0] v_wa, v_ra, c_wa, c_ra;
  logic [7:0] v_wd, c_wd, seed_wd, v_rd_q, c_rd_q, seed_rd_q;
  logic [7:0] seed_wa, seed_ra;

  sha_req_t     sha_req;
  logic [159:0] digest;
  logic         sha_done;
  pk_req_t      pk_req;
  logic [7:0]   pk_data;
  logic         pk_ready;

  logic       accept, gen_ok;
  logic [7:0] req_sat;

  function automatic logic [7:0] job_len(job_e j, logic [7:0] n);
    logic [7:0] l;
    case (j)
      JOB_INST:   l = n + 8'd5;
      JOB_RESEED: l = n + 8'd61;
      JOB_DFC:    l = 8'd61;
      JOB_GEN:    l = 8'(SEEDLEN);
      JOB_HV:     l = 8'(SEEDLEN + 1);
      default:    l = 8'd0;
    endcase
    return l;
  endfunction

  // Padded length in whole 64-byte blocks: room for 0x80 and 8 length bytes.
  function automatic logic [8:0] job_tot(logic [7:0] l);
    logic [8:0] s;
    s = {1'b0, l} + 9'd72;
    return {s[8:6], 6'd0};
  endfunction

  function automatic logic [3:0] blocks_for(logic [7:0] r);
    logic [3:0] b;
    b = '0;
    for (int i = 0; i < MAX_REQ_BYTES / DIGLEN; i++) begin
      if (r > 8'(DIGLEN * i)) b = b + 4'd1;
    end
    return b;
  endfunction

  function automatic logic [7:0] dig_byte(logic [159:0] d, logic [4:0] idx);
    logic [159:0] s;
    s = d << {idx, 3'b000};
    return s[159:152];
  endfunction

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign gen_ok  = seeded_q && (cnt_q != 32'd0) && (cnt_q <= {1'b0, limit_q});
  assign req_sat = (s_axis_tdata[15:8] > 8'(MAX_REQ_BYTES)) ? 8'(MAX_REQ_BYTES)
                                                            : s_axis_tdata[15:8];

  always_comb begin
    logic       do_start;
    job_e       sjob;
    logic [7:0] n_use, p, pre, blen, ld;
    logic [10:0] lbits, acc;
    logic [7:0] vt, ct, ht, cntt, nt;
    logic [3:0] m;
    logic [5:0] hidx, cidx, cbase;
    logic [31:0] cs;

    state_d  = state_q;  job_d    = job_q;    pass_d   = pass_q;
    fsel_d   = fsel_q;   fconst_d = fconst_q; st_d     = st_q;
    dfi_d    = dfi_q;    q_d      = q_q;      tot_d    = tot_q;
    len_d    = len_q;    first_d  = first_q;  blk_d    = blk_q;
    k_d      = k_q;      carry_d  = carry_q;  blocks_d = blocks_q;
    rem_d    = rem_q;    cnt_d    = cnt_q;    seeded_d = seeded_q;
    fill_d   = fill_q;   nseed_d  = nseed_q;  hv_d     = hv_q;

    v_we = 1'b0; v_wa = '0; v_wd = '0; v_ra = '0;
    c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
    seed_we = 1'b0; seed_wa = fill_q; seed_wd = s_axis_tdata[7:0]; seed_ra = '0;
    sha_req = '0;
    pk_req  = '0;
    pk_data = dig_byte(digest, k_q[4:0]);

    do_start = 1'b0;
    sjob     = job_q;
    n_use    = nseed_q;
    p        = q_q[7:0];
    pre      = '0;
    blen     = '0;
    ld       = '0;
    lbits    = {len_q, 3'b000};
    acc      = '0;
    vt = '0; ct = '0; ht = '0; cntt = '0; nt = '0;
    m    = (blocks_q == 4'd0) ? 4'd0 : blocks_q - 4'd1;
    hidx = k_q - 6'd35;
    cidx = k_q - 6'd51;
    cs   = cnt_q << {cidx[1:0], 3'b000};
    cbase = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!s_axis_tuser) begin
            n_use = fill_q;
            if (fill_q < 8'(SEED_CAP)) begin
              seed_we = 1'b1;
              n_use   = fill_q + 8'd1;
              fill_d  = n_use;
            end
            if (s_axis_tlast) begin
              nseed_d  = n_use;
              dfi_d    = 2'd1;
              sjob     = seeded_q ? JOB_RESEED : JOB_INST;
              do_start = 1'b1;
            end
          end else if (!gen_ok) begin
            st_d    = STATUS_RESEED;
            state_d = ST_STATUS;
          end else begin
            rem_d    = req_sat;
            blocks_d = blocks_for(req_sat);
            sjob     = JOB_HV;
            do_start = 1'b1;
          end
        end
      end

      ST_FILL_RD: begin
        fsel_d = SRC_CONST;
        case (p[2:0])
          3'd0:    pre = {6'd0, dfi_q};
          3'd3:    pre = 8'h01;
          3'd4:    pre = 8'hB8;
          default: pre = 8'h00;
        endcase
        if (q_q < {1'b0, len_q}) begin
          case (job_q)
            JOB_INST: begin
              if (p < 8'd5) fconst_d = pre;
              else begin fsel_d = SRC_SEED; seed_ra = p - 8'd5; end
            end
            JOB_RESEED: begin
              if (p < 8'd5) fconst_d = pre;
              else if (p == 8'd5) fconst_d = 8'h01;
              else if (p < 8'd61) begin fsel_d = SRC_V; ld = p - 8'd6; end
              else begin fsel_d = SRC_SEED; seed_ra = p - 8'd61; end
            end
            JOB_DFC: begin
              if (p < 8'd5) fconst_d = pre;
              else if (p == 8'd5) fconst_d = 8'h00;
              else begin fsel_d = SRC_V; ld = p - 8'd6; end
            end
            JOB_GEN: begin
              fsel_d = SRC_V;
              ld     = p;
            end
            JOB_HV: begin
              if (p == 8'd0) fconst_d = 8'h03;
              else begin fsel_d = SRC_V; ld = p - 8'd1; end
            end
            default: fconst_d = 8'h00;
          endcase
        end else if (q_q == {1'b0, len_q}) begin
          fconst_d = 8'h80;
        end else if (q_q == tot_q - 9'd2) begin
          fconst_d = {5'd0, lbits[10:8]};
        end else if (q_q == tot_q - 9'd1) begin
          fconst_d = lbits[7:0];
        end else begin
          fconst_d = 8'h00;
        end
        v_ra    = ld[5:0];
        state_d = ST_FILL_WR;
      end

      ST_FILL_WR: begin
        case (fsel_q)
          SRC_V:    blen = v_rd_q;
          SRC_SEED: blen = seed_rd_q;
          default:  blen = fconst_q;
        endcase
        blk_d = {blk_q[503:0], blen};
        q_d   = q_q + 9'd1;
        if (q_q[5:0] == 6'd63) begin
          sha_req.start = 1'b1;
          sha_req.init  = first_q;
          first_d       = 1'b0;
          state_d       = ST_HASH;
        end else begin
          state_d = ST_FILL_RD;
        end
      end

      ST_HASH: begin
        if (sha_done) begin
          if (q_q == tot_q) begin
            k_d = '0;
            if (job_q == JOB_HV) begin
              hv_d = digest;
              if (blocks_q == 4'd0) begin
                pass_d  = PASS_UPD;
                k_d     = V_LAST;
                carry_d = '0;
                state_d = ST_PASS_RD;
              end else begin
                sjob     = JOB_GEN;
                do_start = 1'b1;
              end
            end else begin
              state_d = ST_DIG;
            end
          end else begin
            state_d = ST_FILL_RD;
          end
        end
      end

      ST_DIG: begin
        if (job_q == JOB_GEN) begin
          pk_req.byte_valid = 1'b1;
          pk_req.byte_final = (rem_q == 8'd1);
          if (pk_ready) begin
            rem_d = rem_q - 8'd1;
            k_d   = k_q + 6'd1;
            if (rem_q == 8'd1 || k_q == 6'(DIGLEN - 1)) begin
              pass_d  = (rem_q == 8'd1) ? PASS_UPD : PASS_INC;
              k_d     = V_LAST;
              carry_d = '0;
              state_d = ST_PASS_RD;
            end
          end
        end else begin
          // Hash_df output bytes land in C; the seed paths copy them to V later.
          case (dfi_q)
            2'd2:    cbase = 6'(DIGLEN);
            2'd3:    cbase = 6'(2 * DIGLEN);
            default: cbase = 6'd0;
          endcase
          c_wa = cbase + k_q;
          c_wd = dig_byte(digest, k_q[4:0]);
          c_we = (c_wa < 6'(SEEDLEN));
          k_d  = k_q + 6'd1;
          if (k_q == 6'(DIGLEN - 1)) begin
            if (dfi_q != 2'd3) begin
              dfi_d    = dfi_q + 2'd1;
              sjob     = job_q;
              do_start = 1'b1;
            end else if (job_q == JOB_DFC) begin
              cnt_d    = 32'd1;
              seeded_d = 1'b1;
              fill_d   = '0;
              st_d     = STATUS_SEEDED;
              state_d  = ST_STATUS;
            end else begin
              pass_d  = PASS_COPY;
              k_d     = V_LAST;
              carry_d = '0;
              state_d = ST_PASS_RD;
            end
          end
        end
      end

      ST_PASS_RD: begin
        v_ra    = k_q;
        c_ra    = k_q;
        state_d = ST_PASS_WR;
      end

      ST_PASS_WR: begin
        case (pass_q)
          PASS_COPY: begin
            ct = c_rd_q;
          end
          PASS_INC: begin
            vt = v_rd_q;
          end
          default: begin
            vt = v_rd_q;
            ct = c_rd_q;
            if (k_q >= 6'd35) ht = dig_byte(hv_q, hidx[4:0]);
            if (k_q >= 6'd51) cntt = cs[31:24];
            if (m != 4'd0) nt = (k_q == V_LAST) ? 8'd0 - {4'd0, m} : 8'hFF;
          end
        endcase
        acc = 11'(vt) + 11'(ct) + 11'(ht) + 11'(cntt) + 11'(nt) + 11'(carry_q);
        if (pass_q == PASS_INC && k_q == V_LAST) acc = acc + 11'd1;
        v_we    = 1'b1;
        v_wa    = k_q;
        v_wd    = acc[7:0];
        carry_d = acc[10:8];
        if (k_q == 6'd0) begin
          case (pass_q)
            PASS_COPY: begin
              dfi_d    = 2'd1;
              sjob     = JOB_DFC;
              do_start = 1'b1;
            end
            PASS_INC: begin
              sjob     = JOB_GEN;
              do_start = 1'b1;
            end
            default: begin
              cnt_d = cnt_q + 32'd1;
              if (blocks_q == 4'd0) begin
                st_d    = STATUS_DATA;
                state_d = ST_STATUS;
              end else begin
                state_d = ST_IDLE;
              end
            end
          endcase
        end else begin
          k_d     = k_q - 6'd1;
          state_d = ST_PASS_RD;
        end
      end

      ST_STATUS: begin
        pk_req.st_valid = 1'b1;
        pk_req.st_code  = st_q;
        if (pk_ready) state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase

    if (do_start) begin
      job_d   = sjob;
      len_d   = job_len(sjob, n_use);
      tot_d   = job_tot(job_len(sjob, n_use));
      q_d     = '0;
      first_d = 1'b1;
      state_d = ST_FILL_RD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      job_q    <= JOB_INST;
      pass_q   <= PASS_COPY;
      st_q     <= STATUS_DATA;
      dfi_q    <= 2'd1;
      q_q      <= '0;
      tot_q    <= '0;
      len_q    <= '0;
      first_q  <= 1'b0;
      k_q      <= '0;
      carry_q  <= '0;
      blocks_q <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      seeded_q <= 1'b0;
      fill_q   <= '0;
      nseed_q  <= '0;
      limit_q  <= 31'h7FFF_FFFF;
    end else begin
      state_q  <= state_d;
      job_q    <= job_d;
      pass_q   <= pass_d;
      st_q     <= st_d;
      dfi_q    <= dfi_d;
      q_q      <= q_d;
      tot_q    <= tot_d;
      len_q    <= len_d;
      first_q  <= first_d;
      k_q      <= k_d;
      carry_q  <= carry_d;
      blocks_q <= blocks_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      seeded_q <= seeded_d;
      fill_q   <= fill_d;
      nseed_q  <= nseed_d;
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q    <= blk_d;
    hv_q     <= hv_d;
    fsel_q   <= fsel_d;
    fconst_q <= fconst_d;
  end

  always_ff @(posedge clk_i) begin
    if (v_we) v_mem[v_wa] <= v_wd;
    v_rd_q <= v_mem[v_ra];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) c_mem[c_wa] <= c_wd;
    c_rd_q <= c_mem[c_ra];
  end

  always_ff @(posedge clk_i) begin
    if (seed_we) seed_mem[seed_wa] <= seed_wd;
    seed_rd_q <= seed_mem[seed_ra];
  end

  hdrbg_sha_core u_sha (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (sha_req),
    .block_i  (blk_d),
    .digest_o (digest),
    .done_o   (sha_done)
  );

  hdrbg_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (pk_req),
    .data_i        (pk_data),
    .ready_o       (pk_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  `HDRBG_ASSERT(a_fill_cap, clk_i, rst_ni, fill_q <= 8'(SEED_CAP))
  `HDRBG_ASSERT(a_done_in_hash, clk_i, rst_ni, sha_done |-> state_q == ST_HASH)
  `HDRBG_ASSERT(a_seeded_cnt, clk_i, rst_ni, seeded_q |-> cnt_q != 32'd0)
  `HDRBG_ASSERT(a_refuse_gen, clk_i, rst_ni, (accept && s_axis_tuser && !gen_ok) |=> state_q == ST_STATUS)

endmodule

`default_nettype wire

[sim/hash_drbg_sha1_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_drbg_sha1_checker
// Watches the input, output and configuration channels of the SHA-1
// Hash_DRBG block. It predicts V, C, the reseed counter and the seed buffer
// for every accepted item, queues the words that the block should emit, and
// compares each emitted word with the oldest word in that queue.
// ----------------------------------------------------------------------------
module hash_drbg_sha1_checker
  import hdrbg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // seed_byte[7:0], request_bytes[15:8]
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // action[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,   // random_word[63:0], valid_bytes[67:64], zero
  input  logic        m_axis_tlast,
  input  logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [30:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  typedef logic [7:0] octets_t[$];

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    status_e     status;
  } drbg_word_t;

  logic [439:0] v_state;
  logic [439:0] c_state;
  logic [31:0]  reseed_cnt;
  logic         seeded;
  logic [30:0]  reseed_limit;
  octets_t      seed_bytes;
  drbg_word_t   expected_words[$];

  assign pending_o = expected_words.size();

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [159:0] sha1_digest(input octets_t msg);
    octets_t        m;
    logic [31:0]    h[5];
    logic [31:0]    w[80];
    logic [31:0]    a, b, c, d, e, f, k, t;
    longint unsigned bits;
    m = msg;
    bits = longint'(msg.size()) * 8;
    m.push_back(8'h80);
    while (m.size() % 64 != 56) m.push_back(8'h00);
    for (int i = 7; i >= 0; i--) m.push_back(8'(bits >> (8 * i)));
    for (int i = 0; i < 5; i++) h[i] = SHA1_IV[159 - 32 * i -: 32];
    for (int blk = 0; blk < m.size() / 64; blk++) begin
      for (int i = 0; i < 16; i++)
        w[i] = {m[64 * blk + 4 * i], m[64 * blk + 4 * i + 1],
                m[64 * blk + 4 * i + 2], m[64 * blk + 4 * i + 3]};
      for (int i = 16; i < 80; i++)
        w[i] = rol(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d); k = 32'h5A827999;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = 32'h6ED9EBA1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d; k = 32'hCA62C1D6;
        end
        t = rol(a, 5) + f + e + k + w[i];
        e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    end
    return {h[0], h[1], h[2], h[3], h[4]};
  endfunction

  // Appends a 440-bit value as 55 bytes, most significant byte first.
  function automatic void put_seedlen(ref octets_t q, input logic [439:0] x);
    for (int i = 0; i < SEEDLEN; i++) q.push_back(x[439 - 8 * i -: 8]);
  endfunction

  function automatic logic [439:0] derive(input octets_t material);
    octets_t      m;
    logic [479:0] acc;
    for (int i = 1; i <= 3; i++) begin
      m = {8'(i), 8'h00, 8'h00, 8'h01, 8'hB8};
      foreach (material[j]) m.push_back(material[j]);
      acc[479 - 160 * (i - 1) -: 160] = sha1_digest(m);
    end
    return acc[479:40];
  endfunction

  function automatic void push_word(input logic [63:0] word, input int nb,
                                    input logic last, input status_e st);
    drbg_word_t x;
    x.word = word; x.nbytes = 4'(nb); x.last = last; x.status = st;
    expected_words.push_back(x);
  endfunction

  function automatic void take_seed_byte(input logic [7:0] b, input logic last);
    octets_t mat;
    if (seed_bytes.size() < SEED_CAP) seed_bytes.push_back(b);
    if (!last) return;
    if (seeded) begin
      mat.push_back(8'h01);
      put_seedlen(mat, v_state);
    end
    foreach (seed_bytes[i]) mat.push_back(seed_bytes[i]);
    v_state = derive(mat);
    mat = {8'h00};
    put_seedlen(mat, v_state);
    c_state = derive(mat);
    reseed_cnt = 1;
    seeded = 1'b1;
    seed_bytes.delete();
    push_word('0, 0, 1'b1, STATUS_SEEDED);
  endfunction

  function automatic void generate_bytes(input logic [7:0] req_in);
    octets_t      data_q, out_q;
    logic [439:0] data;
    logic [159:0] vhash;
    logic [63:0]  word;
    int           req, nwords, nb;
    if (!seeded || reseed_cnt == 0 || reseed_cnt > {1'b0, reseed_limit}) begin
      push_word('0, 0, 1'b1, STATUS_RESEED);
      return;
    end
    req = (req_in > MAX_REQ_BYTES) ? MAX_REQ_BYTES : req_in;
    data = v_state;
    for (int i = 0; i < (req + DIGLEN - 1) / DIGLEN; i++) begin
      data_q.delete();
      put_seedlen(data_q, data);
      vhash = sha1_digest(data_q);
      for (int j = 0; j < DIGLEN; j++) out_q.push_back(vhash[159 - 8 * j -: 8]);
      data = data + 440'd1;
    end
    data_q = {8'h03};
    put_seedlen(data_q, v_state);
    vhash = sha1_digest(data_q);
    v_state = v_state + c_state + 440'(vhash) + 440'(reseed_cnt);
    reseed_cnt++;
    if (req == 0) begin
      push_word('0, 0, 1'b1, STATUS_DATA);
      return;
    end
    nwords = (req + 7) / 8;
    for (int i = 0; i < nwords; i++) begin
      nb = (req - 8 * i > 8) ? 8 : req - 8 * i;
      word = '0;
      for (int j = 0; j < nb; j++) word[63 - 8 * j -: 8] = out_q[8 * i + j];
      push_word(word, nb, i + 1 == nwords, STATUS_DATA);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, exp);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drbg_word_t x;
    if (!rst_ni) begin
      v_state <= '0;
      c_state <= '0;
      reseed_cnt <= '0;
      seeded <= 1'b0;
      reseed_limit <= 31'h7fffffff;
      seed_bytes.delete();
      expected_words.delete();
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) reseed_limit = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (!s_axis_tuser) take_seed_byte(s_axis_tdata[7:0], s_axis_tlast);
        else generate_bytes(s_axis_tdata[15:8]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata[63:0], '0);
        end else begin
          x = expected_words.pop_front();
          if (m_axis_tdata[63:0] !== x.word)
            report_mismatch("random_word", m_axis_tdata[63:0], x.word);
          if (m_axis_tdata[67:64] !== x.nbytes)
            report_mismatch("valid_bytes", m_axis_tdata[67:64], x.nbytes);
          if (m_axis_tlast !== x.last)
            report_mismatch("last_word", m_axis_tlast, x.last);
          if (m_axis_tuser !== x.status)
            report_mismatch("status", m_axis_tuser, x.status);
        end
      end
    end
  end

endmodule

[sim/hash_drbg_sha1_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_drbg_sha1_top_test
// Drives seed bytes, generate requests and reseed-limit writes into the
// SHA-1 Hash_DRBG block with random gaps and output stalls; the checker
// beside the block predicts and compares every emitted word.
// ----------------------------------------------------------------------------
module hash_drbg_sha1_top_test;
  import hdrbg_pkg::*;

  localparam int IDLE_LIMIT = 50000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 330;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [30:0] cfg_data_i;
  int          errors;
  int          pending;
  int          items;
  int          idle_cycles;
  bit          calm;
  bit          hold_out;

  hash_drbg_sha1_top dut (.*);

  hash_drbg_sha1_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .m_axis_tuser, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: cycles in which no transfer happens on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output side: random stalls, one long hold-off on request.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_out = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(0, 19)) @(posedge clk_i);
      end
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high afterwards; any pause that follows lowers it first.
  task automatic send_item(input logic action, input logic [7:0] seed_byte,
                           input logic last, input logic [7:0] req);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= action;
    s_axis_tdata <= {req, seed_byte};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items++;
  endtask

  task automatic seed_run(input int len, input bit mark_last);
    for (int i = 0; i < len; i++)
      send_item(1'b0, 8'($urandom), mark_last && i == len - 1, 8'($urandom));
  endtask

  task automatic gen(input logic [7:0] req);
    send_item(1'b1, 8'($urandom), 1'($urandom), req);
  endtask

  // Sender pause until every expected word has arrived, plus settling time
  // for seed bytes that produce no output.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [30:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_request();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd200;
      2: return 8'd255;
      3: return 8'($urandom);
      default: return 8'($urandom_range(1, 40));
    endcase
  endfunction

  initial begin
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    s_axis_tuser <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    idle_cycles <= 0;
    items = 0;
    calm = 1'b0;
    hold_out = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unseeded generate, extreme bytes, request sizes, reseed.
    gen(8'd8);
    send_item(1'b0, 8'hff, 1'b0, 8'h00);
    send_item(1'b0, 8'h00, 1'b0, 8'hff);
    send_item(1'b0, 8'ha5, 1'b1, 8'h5a);
    gen(8'd1);
    gen(8'd8);
    gen(8'd9);
    gen(8'd20);
    gen(8'd200);
    gen(8'd255);
    gen(8'd0);
    send_item(1'b0, 8'h3c, 1'b1, 8'd0);
    gen(8'd17);
    // Counter limit: both generates under a limit of 1 must ask for a reseed.
    write_limit(31'd1);
    gen(8'd3);
    gen(8'd3);
    send_item(1'b0, 8'h81, 1'b1, 8'd1);
    gen(8'd5);
    write_limit(31'd0);
    gen(8'd5);
    write_limit(31'h7fffffff);
    gen(8'd12);

    // Long output hold-off while the sender keeps offering.
    hold_out = 1'b1;
    gen(8'd200);
    seed_run(10, 1'b0);
    drain();
    // Overfull seed buffer: bytes past the capacity are dropped.
    seed_run(SEED_CAP + 5, 1'b1);
    gen(8'd40);

    while (items < ITEM_TARGET) begin
      calm = items > ITEM_TARGET - 50;
      if (!calm && $urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 2))
          0: write_limit(31'($urandom_range(1, 6)));
          1: write_limit(31'($urandom));
          default: write_limit(31'h7fffffff);
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: seed_run($urandom_range(1, 12), $urandom_range(0, 9) != 0);
        4, 5, 6, 7, 8: gen(pick_request());
        default: send_item(1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
      endcase
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
